// File: src/msa_pkg.sv
package msa_pkg;

    // Channel and sample geometry
    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 10;
    localparam int FRAC_BITS   = 4;

    // Accumulator and result widths
    localparam int SUM_BITS     = 26;
    localparam int COUNT_BITS   = 16;
    localparam int AVG_BITS     = 14;
    localparam int TOTAL_BITS   = 28;
    localparam int TCOUNT_BITS  = 18;
    localparam int PERIOD_BITS  = 16;

    // Divider geometry: total sum with fraction bits, and the widest divisor
    localparam int DIVIDEND_BITS = TOTAL_BITS + FRAC_BITS;
    localparam int DIVISOR_BITS  = TCOUNT_BITS;
    localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);

    // Number of quotients per report: one per channel plus the overall average
    localparam int NUM_QUOT  = CHANNELS + 1;
    localparam int QIDX_BITS = $clog2(NUM_QUOT);
    localparam int CH_BITS   = $clog2(CHANNELS);

    // Saturation limits
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_PERIOD   = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_PERIOD   = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPORT_PERIOD = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_MASK     = 4'd3;

    // Register values after reset
    localparam logic [PERIOD_BITS-1:0] FAST_PERIOD_RST   = 16'd100;
    localparam logic [PERIOD_BITS-1:0] SLOW_PERIOD_RST   = 16'd200;
    localparam logic [PERIOD_BITS-1:0] REPORT_PERIOD_RST = 16'd1000;
    localparam logic [CHANNELS-1:0]    SLOW_MASK_RST     = 4'd4;

endpackage

// File: src/multirate_adc_sample_averager.sv
// Multirate ADC sample averager.
//
// Input channel (s_valid/s_ready): one transaction per timer tick, carrying the
// current conversion of all four channels. Fast channels are accumulated every
// fast_period ticks, slow channels (slow_channel_mask) every slow_period ticks.
// Output channel (m_valid/m_ready): one transaction per report_period ticks with
// per-channel averages, the overall average, the total sum and an empty mask.
// Averages carry 4 fraction bits and are truncated; empty channels read 0.
//
// Flow control: a tick that is not a report tick leaves s_ready high. A report
// tick runs five divisions on one shared radix-2 restoring divider, each an
// ST_LOAD state and then the ST_DIV steps, and then loads the output register;
// s_ready is low for that time. The next tick is taken in the cycle after the
// result loads. The output register holds a result while the receiver stalls;
// ticks keep being accepted meanwhile, and a later report waits in its last
// state until the output register is free.
// Reset (aresetn low, synchronous): registers return to their reset values,
// phase counters, sums and counts clear, and no result is pending.
module multirate_adc_sample_averager (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wen,
    input  logic [msa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [msa_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch0,
    input  logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch1,
    input  logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch2,
    input  logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch3,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch0,
    output logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch1,
    output logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch2,
    output logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch3,
    output logic [msa_pkg::AVG_BITS-1:0]           m_avg_all,
    output logic [msa_pkg::TOTAL_BITS-1:0]         m_sum_all,
    output logic [msa_pkg::CHANNELS-1:0]           m_empty_mask
);
    import msa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    typedef struct packed {
        logic                   fire;
        logic [PERIOD_BITS-1:0] phase;
    } phase_step_t;

    function automatic phase_step_t phase_step(input logic [PERIOD_BITS-1:0] phase,
                                               input logic [PERIOD_BITS-1:0] period);
        phase_step_t             r;
        logic [PERIOD_BITS-1:0]  nxt;
        nxt = phase + PERIOD_BITS'(1);
        if ((nxt >= period) || (nxt == '0)) begin
            r.fire  = 1'b1;
            r.phase = '0;
        end else begin
            r.fire  = 1'b0;
            r.phase = nxt;
        end
        return r;
    endfunction

    // Configuration registers
    logic [PERIOD_BITS-1:0] fast_period_reg, slow_period_reg, report_period_reg;
    logic [CHANNELS-1:0]    slow_mask_reg;

    // Tick state
    logic [PERIOD_BITS-1:0] fast_phase_reg, slow_phase_reg, report_phase_reg;
    logic [SUM_BITS-1:0]    sum_reg   [CHANNELS];
    logic [COUNT_BITS-1:0]  count_reg [CHANNELS];

    // Sequencer and divider
    state_t                   state_reg, state_next;
    logic [QIDX_BITS-1:0]     qidx_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  divisor_reg;
    logic [TOTAL_BITS-1:0]    total_sum_reg;
    logic [TCOUNT_BITS-1:0]   total_cnt_reg;
    logic [AVG_BITS-1:0]      res_reg [NUM_QUOT];

    // Output register
    logic                     m_valid_reg;
    logic [AVG_BITS-1:0]      avg_out_reg [NUM_QUOT];
    logic [TOTAL_BITS-1:0]    sum_out_reg;
    logic [CHANNELS-1:0]      empty_out_reg;

    logic [SAMPLE_BITS-1:0]   smp [CHANNELS];
    phase_step_t              fast_step, slow_step, report_step;
    logic [SUM_BITS-1:0]      sum_next   [CHANNELS];
    logic [COUNT_BITS-1:0]    count_next [CHANNELS];
    logic                     in_accept;
    logic                     out_free;
    logic                     div_last;
    logic                     quot_is_total;
    logic [CH_BITS-1:0]       ch_sel;
    logic [DIVIDEND_BITS-1:0] load_dividend;
    logic [DIVISOR_BITS-1:0]  load_divisor;
    logic [DIVISOR_BITS:0]    trial;
    logic                     trial_ge;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVIDEND_BITS-1:0] quo_next;
    logic [CHANNELS-1:0]      empty_now;

    assign smp[0] = s_sample_ch0;
    assign smp[1] = s_sample_ch1;
    assign smp[2] = s_sample_ch2;
    assign smp[3] = s_sample_ch3;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Advance the tick counters and accumulate this tick's samples
    always_comb begin
        logic                  take;
        logic [SUM_BITS:0]     sum_add;
        fast_step   = phase_step(fast_phase_reg, fast_period_reg);
        slow_step   = phase_step(slow_phase_reg, slow_period_reg);
        report_step = phase_step(report_phase_reg, report_period_reg);
        for (int c = 0; c < CHANNELS; c++) begin
            take    = slow_mask_reg[c] ? slow_step.fire : fast_step.fire;
            sum_add = {1'b0, sum_reg[c]} + (SUM_BITS+1)'(smp[c]);
            if (take) begin
                sum_next[c]   = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX
                                                             : sum_add[SUM_BITS-1:0];
                count_next[c] = (count_reg[c] == COUNT_MAX) ? COUNT_MAX
                                                            : count_reg[c] + COUNT_BITS'(1);
            end else begin
                sum_next[c]   = sum_reg[c];
                count_next[c] = count_reg[c];
            end
        end
    end

    // Mark channels that took no samples
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            empty_now[c] = (count_reg[c] == '0);
        end
    end

    // Select the operands for the next division
    assign quot_is_total = (qidx_reg == QIDX_BITS'(CHANNELS));
    assign ch_sel        = qidx_reg[CH_BITS-1:0];

    always_comb begin
        if (quot_is_total) begin
            load_dividend = {total_sum_reg, {FRAC_BITS{1'b0}}};
            load_divisor  = total_cnt_reg;
        end else begin
            load_dividend = DIVIDEND_BITS'({sum_reg[ch_sel], {FRAC_BITS{1'b0}}});
            load_divisor  = DIVISOR_BITS'(count_reg[ch_sel]);
        end
    end

    // One restoring division step
    assign trial    = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});
    assign rem_next = trial_ge ? DIVISOR_BITS'(trial - {1'b0, divisor_reg})
                               : trial[DIVISOR_BITS-1:0];
    assign quo_next = {quo_reg[DIVIDEND_BITS-2:0], trial_ge};
    assign div_last = (step_reg == STEP_BITS'(DIVIDEND_BITS - 1));

    // Sequence the report divisions
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && report_step.fire) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = quot_is_total ? ST_HOLD : ST_LOAD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Write configuration registers; ignore indexes past the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_period_reg   <= FAST_PERIOD_RST;
            slow_period_reg   <= SLOW_PERIOD_RST;
            report_period_reg <= REPORT_PERIOD_RST;
            slow_mask_reg     <= SLOW_MASK_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_FAST_PERIOD:   fast_period_reg   <= cfg_wdata;
                REG_SLOW_PERIOD:   slow_period_reg   <= cfg_wdata;
                REG_REPORT_PERIOD: report_period_reg <= cfg_wdata;
                REG_SLOW_MASK:     slow_mask_reg     <= cfg_wdata[CHANNELS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Update phases and accumulators on each tick; clear after a report
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_phase_reg   <= '0;
            slow_phase_reg   <= '0;
            report_phase_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c]   <= '0;
                count_reg[c] <= '0;
            end
        end else if (in_accept) begin
            fast_phase_reg   <= fast_step.phase;
            slow_phase_reg   <= slow_step.phase;
            report_phase_reg <= report_step.phase;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c]   <= sum_next[c];
                count_reg[c] <= count_next[c];
            end
        end else if ((state_reg == ST_HOLD) && out_free) begin
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c]   <= '0;
                count_reg[c] <= '0;
            end
        end
    end

    // Divider control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qidx_reg <= '0;
            step_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    qidx_reg <= '0;
                end
                ST_LOAD: begin
                    step_reg <= '0;
                end
                ST_DIV: begin
                    step_reg <= step_reg + STEP_BITS'(1);
                    if (div_last && !quot_is_total) begin
                        qidx_reg <= qidx_reg + QIDX_BITS'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Divider datapath and running totals
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                total_sum_reg <= '0;
                total_cnt_reg <= '0;
            end
            ST_LOAD: begin
                rem_reg     <= '0;
                quo_reg     <= load_dividend;
                divisor_reg <= load_divisor;
                if (!quot_is_total) begin
                    total_sum_reg <= total_sum_reg + TOTAL_BITS'(sum_reg[ch_sel]);
                    total_cnt_reg <= total_cnt_reg + TCOUNT_BITS'(count_reg[ch_sel]);
                end
            end
            ST_DIV: begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (div_last) begin
                    res_reg[qidx_reg] <= (divisor_reg == '0) ? '0
                                                             : quo_next[AVG_BITS-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Load the output register and hold it until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_HOLD) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_HOLD) && out_free) begin
            for (int q = 0; q < NUM_QUOT; q++) begin
                avg_out_reg[q] <= res_reg[q];
            end
            sum_out_reg   <= total_sum_reg;
            empty_out_reg <= empty_now;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_avg_ch0    = avg_out_reg[0];
    assign m_avg_ch1    = avg_out_reg[1];
    assign m_avg_ch2    = avg_out_reg[2];
    assign m_avg_ch3    = avg_out_reg[3];
    assign m_avg_all    = avg_out_reg[CHANNELS];
    assign m_sum_all    = sum_out_reg;
    assign m_empty_mask = empty_out_reg;

endmodule

// File: src/msa_checker.sv
module msa_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   cfg_wen,
    input logic [msa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input logic [msa_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch0,
    input logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch1,
    input logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch2,
    input logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch3,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch0,
    input logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch1,
    input logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch2,
    input logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch3,
    input logic [msa_pkg::AVG_BITS-1:0]           m_avg_all,
    input logic [msa_pkg::TOTAL_BITS-1:0]         m_sum_all,
    input logic [msa_pkg::CHANNELS-1:0]           m_empty_mask
);
    // Drop any pending result on reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum_all) && $stable(m_avg_all))
        else $error("stalled result changed");

    // An empty channel reports a zero average
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_empty_mask[0] || m_avg_ch0 == '0) &&
                    (!m_empty_mask[1] || m_avg_ch1 == '0) &&
                    (!m_empty_mask[2] || m_avg_ch2 == '0) &&
                    (!m_empty_mask[3] || m_avg_ch3 == '0))
        else $error("empty channel with nonzero average");

    // No samples at all means zero total and zero overall average
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_empty_mask == '1) |-> (m_sum_all == '0) && (m_avg_all == '0))
        else $error("empty report with nonzero totals");

    // A new result never loads in the cycle after a tick transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("result loaded right after a tick");

endmodule

bind multirate_adc_sample_averager msa_checker u_msa_checker (.*);

// File: verif/msa_report_checker.sv
module msa_report_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wen,
    input  logic [msa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [msa_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch0,
    input  logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch1,
    input  logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch2,
    input  logic [msa_pkg::SAMPLE_BITS-1:0]        s_sample_ch3,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch0,
    input  logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch1,
    input  logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch2,
    input  logic [msa_pkg::AVG_BITS-1:0]           m_avg_ch3,
    input  logic [msa_pkg::AVG_BITS-1:0]           m_avg_all,
    input  logic [msa_pkg::TOTAL_BITS-1:0]         m_sum_all,
    input  logic [msa_pkg::CHANNELS-1:0]           m_empty_mask,
    output int                                     mismatches,
    output int                                     reports_left,
    output int                                     reports_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import msa_pkg::*;

    // One predicted report transaction
    typedef struct {
        logic [AVG_BITS-1:0]   avg [CHANNELS];
        logic [AVG_BITS-1:0]   avg_all;
        logic [TOTAL_BITS-1:0] sum_all;
        logic [CHANNELS-1:0]   empty;
    } avg_report_t;

    avg_report_t pending_reports [$];

    // Shadow registers
    logic [PERIOD_BITS-1:0] fast_period   = FAST_PERIOD_RST;
    logic [PERIOD_BITS-1:0] slow_period   = SLOW_PERIOD_RST;
    logic [PERIOD_BITS-1:0] report_period = REPORT_PERIOD_RST;
    logic [CHANNELS-1:0]    slow_mask     = SLOW_MASK_RST;

    // Shadow tick counters and accumulators
    logic [PERIOD_BITS-1:0] fast_phase   = '0;
    logic [PERIOD_BITS-1:0] slow_phase   = '0;
    logic [PERIOD_BITS-1:0] report_phase = '0;
    logic [SUM_BITS-1:0]    ch_sum   [CHANNELS];
    logic [COUNT_BITS-1:0]  ch_count [CHANNELS];

    int errors  = 0;
    int checked = 0;

    // Advance a tick counter; the top bit of the result says the event fired
    function automatic logic [PERIOD_BITS:0] advance_phase(
        input logic [PERIOD_BITS-1:0] phase,
        input logic [PERIOD_BITS-1:0] period
    );
        logic [PERIOD_BITS-1:0] next;
        next = phase + 1'b1;
        if (next >= period || next == '0) begin
            return {1'b1, {PERIOD_BITS{1'b0}}};
        end
        return {1'b0, next};
    endfunction

    // Truncated average with four fraction bits, zero for an empty set
    function automatic logic [AVG_BITS-1:0] fixed_avg(
        input longint unsigned sum,
        input longint unsigned count
    );
        longint unsigned quot;
        if (count == 0) begin
            return '0;
        end
        quot = (sum << FRAC_BITS) / count;
        return quot[AVG_BITS-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        errors++;
        $display("%0t ns: %s", $time, what);
    endtask

    // Clear the accumulated sums and counts
    task automatic clear_accumulators();
        for (int c = 0; c < CHANNELS; c++) begin
            ch_sum[c]   = '0;
            ch_count[c] = '0;
        end
    endtask

    // Accumulate one tick and predict the report it may cause
    task automatic take_tick();
        logic [SAMPLE_BITS-1:0] smp [CHANNELS];
        logic [PERIOD_BITS:0]   adv;
        bit                     fast_hit;
        bit                     slow_hit;
        bit                     report_hit;
        longint unsigned        acc;
        longint unsigned        total;
        longint unsigned        total_count;
        avg_report_t            rep;

        smp[0] = s_sample_ch0;
        smp[1] = s_sample_ch1;
        smp[2] = s_sample_ch2;
        smp[3] = s_sample_ch3;

        adv = advance_phase(fast_phase, fast_period);
        fast_hit = adv[PERIOD_BITS];
        fast_phase = adv[PERIOD_BITS-1:0];
        adv = advance_phase(slow_phase, slow_period);
        slow_hit = adv[PERIOD_BITS];
        slow_phase = adv[PERIOD_BITS-1:0];
        adv = advance_phase(report_phase, report_period);
        report_hit = adv[PERIOD_BITS];
        report_phase = adv[PERIOD_BITS-1:0];

        // Sample first, with saturating sums and counts
        for (int c = 0; c < CHANNELS; c++) begin
            if (slow_mask[c] ? slow_hit : fast_hit) begin
                acc = ch_sum[c] + smp[c];
                ch_sum[c] = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_BITS-1:0];
                if (ch_count[c] != COUNT_MAX) begin
                    ch_count[c]++;
                end
            end
        end

        if (!report_hit) begin
            return;
        end

        // Build the report, then clear for the next period
        total = 0;
        total_count = 0;
        rep.empty = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            rep.avg[c] = fixed_avg(ch_sum[c], ch_count[c]);
            total += ch_sum[c];
            total_count += ch_count[c];
            if (ch_count[c] == '0) begin
                rep.empty[c] = 1'b1;
            end
        end
        rep.avg_all = fixed_avg(total, total_count);
        rep.sum_all = (total >> TOTAL_BITS) != 0 ? {TOTAL_BITS{1'b1}} : total[TOTAL_BITS-1:0];
        pending_reports.push_back(rep);
        clear_accumulators();
    endtask

    // Compare one report transaction against the oldest prediction
    task automatic check_report();
        logic [AVG_BITS-1:0] got_avg [CHANNELS];
        avg_report_t         want;

        got_avg[0] = m_avg_ch0;
        got_avg[1] = m_avg_ch1;
        got_avg[2] = m_avg_ch2;
        got_avg[3] = m_avg_ch3;

        if (pending_reports.size() == 0) begin
            flag_mismatch("report transaction arrived with no prediction waiting");
            return;
        end
        want = pending_reports.pop_front();
        checked++;
        for (int c = 0; c < CHANNELS; c++) begin
            if (got_avg[c] !== want.avg[c]) begin
                flag_mismatch($sformatf("report %0d avg_ch%0d: got %0d, expected %0d",
                                        checked, c, got_avg[c], want.avg[c]));
            end
        end
        if (m_avg_all !== want.avg_all) begin
            flag_mismatch($sformatf("report %0d avg_all: got %0d, expected %0d",
                                    checked, m_avg_all, want.avg_all));
        end
        if (m_sum_all !== want.sum_all) begin
            flag_mismatch($sformatf("report %0d sum_all: got %0d, expected %0d",
                                    checked, m_sum_all, want.sum_all));
        end
        if (m_empty_mask !== want.empty) begin
            flag_mismatch($sformatf("report %0d empty_mask: got %b, expected %b",
                                    checked, m_empty_mask, want.empty));
        end
    endtask

    // Track reset, register writes and both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            fast_period   = FAST_PERIOD_RST;
            slow_period   = SLOW_PERIOD_RST;
            report_period = REPORT_PERIOD_RST;
            slow_mask     = SLOW_MASK_RST;
            fast_phase    = '0;
            slow_phase    = '0;
            report_phase  = '0;
            clear_accumulators();
            pending_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_report();
            end
            if (cfg_wen) begin
                case (cfg_index)
                    REG_FAST_PERIOD:   fast_period   = cfg_wdata;
                    REG_SLOW_PERIOD:   slow_period   = cfg_wdata;
                    REG_REPORT_PERIOD: report_period = cfg_wdata;
                    REG_SLOW_MASK:     slow_mask     = cfg_wdata[CHANNELS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                take_tick();
            end
        end
        mismatches      <= errors;
        reports_left    <= pending_reports.size();
        reports_checked <= checked;
    end

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msa_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 200;
    localparam int RANDOM_PHASES   = 12;
    localparam int TICKS_PER_PHASE = 140;

    logic                      aclk         = 1'b0;
    logic                      aresetn      = 1'b0;
    logic                      cfg_wen      = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata    = '0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic [SAMPLE_BITS-1:0]    s_sample_ch0 = '0;
    logic [SAMPLE_BITS-1:0]    s_sample_ch1 = '0;
    logic [SAMPLE_BITS-1:0]    s_sample_ch2 = '0;
    logic [SAMPLE_BITS-1:0]    s_sample_ch3 = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    logic [AVG_BITS-1:0]       m_avg_ch0;
    logic [AVG_BITS-1:0]       m_avg_ch1;
    logic [AVG_BITS-1:0]       m_avg_ch2;
    logic [AVG_BITS-1:0]       m_avg_ch3;
    logic [AVG_BITS-1:0]       m_avg_all;
    logic [TOTAL_BITS-1:0]     m_sum_all;
    logic [CHANNELS-1:0]       m_empty_mask;

    int mismatches;
    int reports_left;
    int reports_checked;

    int send_idle_pct  = 25;
    int recv_idle_pct  = 47;
    int ticks_sent     = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;

    multirate_adc_sample_averager u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_ch0 (s_sample_ch0),
        .s_sample_ch1 (s_sample_ch1),
        .s_sample_ch2 (s_sample_ch2),
        .s_sample_ch3 (s_sample_ch3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_avg_ch0    (m_avg_ch0),
        .m_avg_ch1    (m_avg_ch1),
        .m_avg_ch2    (m_avg_ch2),
        .m_avg_ch3    (m_avg_ch3),
        .m_avg_all    (m_avg_all),
        .m_sum_all    (m_sum_all),
        .m_empty_mask (m_empty_mask)
    );

    msa_report_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_ch0    (s_sample_ch0),
        .s_sample_ch1    (s_sample_ch1),
        .s_sample_ch2    (s_sample_ch2),
        .s_sample_ch3    (s_sample_ch3),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_avg_ch0       (m_avg_ch0),
        .m_avg_ch1       (m_avg_ch1),
        .m_avg_ch2       (m_avg_ch2),
        .m_avg_ch3       (m_avg_ch3),
        .m_avg_all       (m_avg_all),
        .m_sum_all       (m_sum_all),
        .m_empty_mask    (m_empty_mask),
        .mismatches      (mismatches),
        .reports_left    (reports_left),
        .reports_checked (reports_checked)
    );

    always #1 aclk = ~aclk;

    // Stall the report channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_BITS'($urandom_range(0, 2**SAMPLE_BITS - 1));
        endcase
    endfunction

    // Mostly short periods, with the zero and full-scale extremes now and then
    function automatic logic [PERIOD_BITS-1:0] random_period(input int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PERIOD_BITS'(1);
            2:       return '1;
            default: return PERIOD_BITS'($urandom_range(1, hi));
        endcase
    endfunction

    // Present one tick and hold it until accepted
    task automatic send_tick(
        input logic [SAMPLE_BITS-1:0] ch0,
        input logic [SAMPLE_BITS-1:0] ch1,
        input logic [SAMPLE_BITS-1:0] ch2,
        input logic [SAMPLE_BITS-1:0] ch3
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_sample_ch0 <= ch0;
        s_sample_ch1 <= ch1;
        s_sample_ch2 <= ch2;
        s_sample_ch3 <= ch3;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        ticks_sent++;
    endtask

    task automatic send_random_ticks(input int count);
        repeat (count) begin
            send_tick(random_sample(), random_sample(), random_sample(), random_sample());
        end
    endtask

    // Stop sending, wait for every predicted report, then let the block settle
    task automatic wait_drained(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_left != 0) begin
            @(posedge aclk);
        end
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(
        input logic [CFG_INDEX_BITS-1:0] idx,
        input logic [CFG_DATA_BITS-1:0]  val
    );
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Program all registers while idle; junk upper bits and a dead index too
    task automatic apply_setting(
        input logic [PERIOD_BITS-1:0] fast,
        input logic [PERIOD_BITS-1:0] slow,
        input logic [PERIOD_BITS-1:0] report,
        input logic [CHANNELS-1:0]    mask
    );
        logic [CFG_DATA_BITS-1:0]  mask_word;
        logic [CFG_INDEX_BITS-1:0] dead_index;
        mask_word = CFG_DATA_BITS'($urandom);
        mask_word[CHANNELS-1:0] = mask;
        dead_index = CFG_INDEX_BITS'($urandom_range(REG_SLOW_MASK + 1,
                                                    2**CFG_INDEX_BITS - 1));
        wait_drained(SETTLE_CYCLES);
        write_reg(REG_FAST_PERIOD, fast);
        write_reg(REG_SLOW_PERIOD, slow);
        write_reg(REG_REPORT_PERIOD, report);
        write_reg(REG_SLOW_MASK, mask_word);
        write_reg(dead_index, CFG_DATA_BITS'($urandom));
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Short periods: sample extremes and alternating bit patterns
        apply_setting(1, 2, 3, 4'b1010);
        send_tick('0, '0, '0, '0);
        send_tick('1, '1, '1, '1);
        send_tick(10'h2AA, 10'h155, 10'h2AA, 10'h155);
        send_tick(10'h155, 10'h2AA, 10'h155, 10'h2AA);
        send_tick('1, '0, '1, '0);
        send_tick('0, '1, '0, '1);
        send_tick(10'h001, 10'h200, 10'h3FE, 10'h1FF);
        send_tick('1, '1, '1, '1);

        // Zero periods fire every tick; all channels slow, so only slow-tick reports carry samples
        apply_setting('0, 4, '0, 4'b1111);
        send_random_ticks(6);

        // Fast period never reached, so fast channels stay empty
        apply_setting('1, 1, 2, 4'b0101);
        send_random_ticks(4);

        // Long report period, then lowered below the running phase
        apply_setting(1, '1, 1000, 4'b1000);
        send_random_ticks(5);
        apply_setting(1, '1, 2, 4'b1000);
        send_random_ticks(2);

        // Random settings with random samples, across three idling regimes
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 25;
            end else if (p == 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(random_period(12), random_period(30), random_period(40),
                          CHANNELS'($urandom_range(0, 2**CHANNELS - 1)));
            send_random_ticks(TICKS_PER_PHASE);
        end

        wait_drained(DRAIN_CYCLES);
        $display("covered %0d ticks under %0d register settings, %0d reports compared",
                 ticks_sent, settings_used, reports_checked);
        if (mismatches == 0 && reports_left == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d reports never arrived", mismatches, reports_left);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/msa_pkg.sv
src/multirate_adc_sample_averager.sv
src/msa_checker.sv
verif/msa_report_checker.sv
verif/tb.sv
